// File: rtl/core/rcla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcla_pkg
// Shared types and constants for the run cycle counter with limit alarm.
// ----------------------------------------------------------------------------
package rcla_pkg;

   // run must be held longer than this many ms to qualify on time alone
   localparam logic [31:0] QUALIFY_MS = 32'd700;

   // csr register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_ENABLE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_COUNT      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_COUNT      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_ERROR_CODE = 2'd3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [15:0] ALARM_ERROR_CODE_RST = 16'd505;
   localparam logic [15:0] NO_ERROR             = 16'd0;

   // fastening status codes
   localparam logic [1:0] STATUS_OTHER = 2'd0;

   // stream widths
   localparam int unsigned REQ_W   = 51;
   localparam int unsigned RSP_W   = 50;
   localparam int unsigned TDATA_W = 56;

   typedef struct packed {
      logic        alarm_enable;
      logic [31:0] reset_count;
      logic [31:0] limit_count;
      logic [15:0] alarm_error_code;
   } rcla_cfg_type;

   // first field in the highest bits
   typedef struct packed {
      logic [15:0] error_in;
      logic [1:0]  fastening_status;
      logic        run_on;
      logic [31:0] now_ms;
   } rcla_req_type;

   typedef struct packed {
      logic [31:0] run_total;
      logic        counted;
      logic        alarm_fired;
      logic [15:0] error_out;
   } rcla_rsp_type;

   typedef struct packed {
      logic        prev_run;
      logic [31:0] start_stamp;
      logic        start_valid;
      logic        run_qualified;
      logic        alarm_latched;
      logic [31:0] total_runs;
   } rcla_state_type;

endpackage
`default_nettype wire

// File: rtl/core/rcla_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcla_step
// Combinational update for one poll: limit check, error injection, run
// qualifier and count increment.
// ----------------------------------------------------------------------------
module rcla_step (
   input  var rcla_pkg::rcla_cfg_type   cfg,
   input  var rcla_pkg::rcla_state_type state_cur,
   input  var rcla_pkg::rcla_req_type   req_word,
   output rcla_pkg::rcla_state_type     state_nxt,
   output rcla_pkg::rcla_rsp_type       rsp_word
);
   import rcla_pkg::*;

   logic        over_limit;
   logic        fired;
   logic        rising;
   logic        falling;
   logic [31:0] since_reset;
   logic [31:0] held_ms;

   // runs since the user reset, only meaningful when not negative
   assign since_reset = state_cur.total_runs - cfg.reset_count;
   assign over_limit  = (cfg.limit_count != 32'd0)
                        && (state_cur.total_runs >= cfg.reset_count)
                        && (since_reset > cfg.limit_count);

   assign rising  = !state_cur.prev_run && req_word.run_on;
   assign falling = state_cur.prev_run && !req_word.run_on;

   always_comb begin
      state_nxt = state_cur;
      fired     = 1'b0;

      // one-shot alarm, rearmed when the enabled check fails
      if (cfg.alarm_enable) begin
         if (over_limit) begin
            fired                   = !state_cur.alarm_latched;
            state_nxt.alarm_latched = 1'b1;
         end else begin
            state_nxt.alarm_latched = 1'b0;
         end
      end

      // start stamp on rising edge, dropped while run is low
      state_nxt.prev_run = req_word.run_on;
      if (rising) begin
         state_nxt.start_stamp = req_word.now_ms;
         state_nxt.start_valid = 1'b1;
      end else if (!req_word.run_on) begin
         state_nxt.start_stamp = 32'd0;
         state_nxt.start_valid = 1'b0;
      end

      // qualify on hold time or on a finishing status
      held_ms = req_word.now_ms - state_nxt.start_stamp;
      if (req_word.run_on && state_nxt.start_valid && (held_ms > QUALIFY_MS)) begin
         state_nxt.run_qualified = 1'b1;
      end else if (falling && (req_word.fastening_status != STATUS_OTHER)) begin
         state_nxt.run_qualified = 1'b1;
      end

      // count once run is off
      rsp_word.counted = 1'b0;
      if (!req_word.run_on && state_nxt.run_qualified) begin
         state_nxt.total_runs    = state_cur.total_runs + 32'd1;
         state_nxt.run_qualified = 1'b0;
         rsp_word.counted        = 1'b1;
      end

      rsp_word.alarm_fired = fired;
      rsp_word.error_out   = (fired && (req_word.error_in == NO_ERROR))
                             ? cfg.alarm_error_code : req_word.error_in;
      rsp_word.run_total   = state_nxt.total_runs;
   end

endmodule
`default_nettype wire

// File: rtl/core/run_cycle_counter_limit_alarm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// run_cycle_counter_limit_alarm
// Counts qualified driver runs and raises a one-shot over-limit alarm.
// ----------------------------------------------------------------------------
// Each accepted poll word gives exactly one result word. A poll is captured in
// an input register and evaluated by a single combinational step into the
// output register once that register is free or draining, and one poll can be
// taken every cycle while rsp_tready holds. The step reads the state left by the
// previous poll, and that single registered update is what sets the
// one-word-per-cycle rate. The user must write the csr port only while no poll
// is in flight; the block itself does not enforce this.
module run_cycle_counter_limit_alarm (
   input  wire                                  clock,
   input  wire                                  reset,
   // now_ms[31:0], run_on[32], fastening_status[34:33], error_in[50:35]
   input  wire  [rcla_pkg::TDATA_W-1:0]         req_tdata,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // error_out[15:0], alarm_fired[16], counted[17], run_total[49:18]
   output logic [rcla_pkg::TDATA_W-1:0]         rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   input  wire                                  csr_wr_en,
   input  wire  [rcla_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [rcla_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rcla_pkg::*;

   rcla_cfg_type   cfg_ff;
   rcla_state_type state_ff;
   rcla_state_type state_in;
   rcla_req_type   in_word_ff;
   rcla_rsp_type   out_word_ff;
   rcla_rsp_type   out_word_in;
   logic           in_valid_ff;
   logic           out_valid_ff;
   logic           advance;

   // step the held poll when the output register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alarm_enable     <= 1'b0;
         cfg_ff.reset_count      <= 32'd0;
         cfg_ff.limit_count      <= 32'd0;
         cfg_ff.alarm_error_code <= ALARM_ERROR_CODE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ALARM_ENABLE:     cfg_ff.alarm_enable     <= csr_wdata[0];
            CSR_RESET_COUNT:      cfg_ff.reset_count      <= csr_wdata[31:0];
            CSR_LIMIT_COUNT:      cfg_ff.limit_count      <= csr_wdata[31:0];
            CSR_ALARM_ERROR_CODE: cfg_ff.alarm_error_code <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_word_ff <= rcla_req_type'(req_tdata[REQ_W-1:0]);
      end
   end

   // per-poll update
   rcla_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .req_word  (in_word_ff),
      .state_nxt (state_in),
      .rsp_word  (out_word_in)
   );

   // counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(TDATA_W-RSP_W){1'b0}}, out_word_ff};

   // a reported alarm leaves the latch set until a newer poll replaces it
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.alarm_fired |-> state_ff.alarm_latched)
      else $error("alarm reported without latch set");

   // a counted run leaves no pending qualification behind
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.counted |-> !state_ff.run_qualified)
      else $error("qualification still pending after count");

   // a start stamp is only held while run stays on
   assert property (@(posedge clock) disable iff (reset)
      state_ff.start_valid |-> state_ff.prev_run)
      else $error("start stamp held while run is off");

   // a count steps the total by exactly one
   assert property (@(posedge clock) disable iff (reset)
      advance && out_word_in.counted
      |=> state_ff.total_runs == $past(state_ff.total_runs) + 32'd1)
      else $error("total did not step by one");

endmodule
`default_nettype wire
